FILE: hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: shared constants and codes for the buddy page allocator
// Store size, status codes and request codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // pages in the store; field widths of the stream words are sized for it
  localparam int NUM_PAGES = 4096;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_MEM   = 3'd1;
  localparam logic [2:0] ST_BAD_ORD  = 3'd2;
  localparam logic [2:0] ST_MISALIGN = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage

FILE: hdl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator: buddy allocator with per-order LIFO free lists
// Doubly linked free lists in RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// A bad order, or on a free a range or an alignment error, goes from decode
// straight to the done state. An allocation scans up the orders for a
// nonempty list, detaches its tail and splits down, pushing each upper half;
// a free reads the buddy word, merging up while the buddy is free, then pushes.
// One request at a time; ready returns the cycle after the result word is
// taken. rst is synchronous; after it a clearing pass writes all NUM_PAGES
// link words to zero before the first request is taken.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER  = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: [0] req_type, [4:1] block_order, [16:5] page_index, zero pad
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: [2:0] status, [14:3] block_index, [27:15] free_blocks_at_order
  output logic [31:0] m_tdata
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int PW = AW + 1;             // page value incl. null
  localparam int NO = MAX_ORDER + 1;
  localparam int OW = 4;
  localparam int LW = 2 * PW + OW + 1;    // prev, next, order, free flag
  localparam logic [PW-1:0] NIL = PW'(NUM_PAGES);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_ASCAN = 5'd3;
  localparam logic [4:0] S_DRD   = 5'd4;
  localparam logic [4:0] S_DRW   = 5'd5;
  localparam logic [4:0] S_DP    = 5'd6;
  localparam logic [4:0] S_DPW   = 5'd7;
  localparam logic [4:0] S_DN    = 5'd8;
  localparam logic [4:0] S_DNW   = 5'd9;
  localparam logic [4:0] S_DFIN  = 5'd10;
  localparam logic [4:0] S_PT    = 5'd11;
  localparam logic [4:0] S_PTW   = 5'd12;
  localparam logic [4:0] S_PB    = 5'd13;
  localparam logic [4:0] S_PFIN  = 5'd14;
  localparam logic [4:0] S_SPLIT = 5'd15;
  localparam logic [4:0] S_FRD   = 5'd16;
  localparam logic [4:0] S_FCHK  = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;
  localparam logic [4:0] S_PTR   = 5'd19;

  logic [4:0] state;
  logic [4:0] ret;            // where detach/push returns to
  logic       req;
  logic [OW-1:0] ord, k;
  logic [PW-1:0] blk, dblk, tgt, pv, nx;
  logic [LW-1:0] rd;
  logic [2:0]    status;
  logic [AW-1:0] result;
  logic [PW-1:0] tail [NO];
  logic [12:0]   cnt [NO];
  logic [AW:0]   clr;

  // link RAM: one port, word = {free, order, next, prev}
  logic          we;
  logic [AW-1:0] addr;
  logic [LW-1:0] wdata;

  bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_link (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rd)
  );

  logic [PW-1:0] rd_prev, rd_next;
  logic [OW-1:0] rd_ord;
  logic          rd_free;
  assign rd_prev = rd[PW-1:0];
  assign rd_next = rd[2*PW-1:PW];
  assign rd_ord  = rd[2*PW+OW-1:2*PW];
  assign rd_free = rd[LW-1];

  logic          in_req;
  logic [OW-1:0] in_ord;
  logic [11:0]   in_idx;
  assign in_req = s_tdata[0];
  assign in_ord = s_tdata[4:1];
  assign in_idx = s_tdata[16:5];

  logic [PW-1:0] buddy;
  assign buddy = blk ^ (PW'(1) << k);

  assign s_tready = (state == S_IDLE);

  // RAM address and write data per state
  always_comb begin
    we    = 1'b0;
    addr  = blk[AW-1:0];
    wdata = rd;
    unique case (state)
      S_CLR: begin
        we = 1'b1; addr = clr[AW-1:0]; wdata = '0;
      end
      S_DRD, S_FCHK: addr = dblk[AW-1:0];
      S_DRW: begin
        we = 1'b1; addr = dblk[AW-1:0]; wdata = {1'b0, rd[LW-2:0]};
      end
      S_DP, S_DPW: addr = pv[AW-1:0];
      S_DN, S_DNW: addr = nx[AW-1:0];
      S_PB: begin
        we = 1'b1; addr = dblk[AW-1:0];
        wdata = {1'b1, k, NIL, tgt};
      end
      S_PTR, S_PTW: addr = tgt[AW-1:0];
      default: ;
    endcase
    if (state == S_DPW) begin
      we = 1'b1; wdata = {rd[LW-1:2*PW], nx, rd_prev};
    end
    if (state == S_DNW) begin
      we = 1'b1; wdata = {rd[LW-1:PW], pv};
    end
    if (state == S_PTW) begin
      we = 1'b1; wdata = {rd[LW-1:2*PW], dblk, rd_prev};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr      <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NO; i++) begin
        tail[i] <= NIL;
        cnt[i]  <= '0;
      end
    end else begin
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(NUM_PAGES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid) begin
          req <= in_req; ord <= in_ord; k <= in_ord;
          blk <= PW'(in_idx); result <= '0; status <= ST_OK;
          state <= S_DEC;
        end
        S_DEC: begin
          if (32'(ord) > MAX_ORDER) begin
            status <= ST_BAD_ORD; state <= S_DONE;
          end else if (req == REQ_ALLOC) begin
            state <= S_ASCAN;
          end else if ((33'(blk) + (33'(1) << ord)) > 33'(NUM_PAGES)) begin
            status <= ST_RANGE; state <= S_DONE;
          end else if ((blk & ((PW'(1) << ord) - 1'b1)) != '0) begin
            status <= ST_MISALIGN; state <= S_DONE;
          end else begin
            state <= S_FRD;
          end
        end
        // one order per cycle looking for a nonempty list
        S_ASCAN: begin
          if (tail[k] != NIL) begin
            dblk <= tail[k]; blk <= tail[k]; ret <= S_SPLIT; state <= S_DRD;
          end else if (32'(k) >= MAX_ORDER) begin
            status <= ST_NO_MEM; state <= S_DONE;
          end else begin
            k <= k + 1'b1;
          end
        end
        // detach dblk from list k; on a free, first check the buddy word
        S_DRD: begin
          if (ret == S_FRD && req == REQ_FREE && !(rd_free && rd_ord == k)) begin
            dblk <= blk; ret <= S_DONE; state <= S_PT;
          end else begin
            state <= S_DRW;
          end
        end
        S_DRW: begin
          pv <= rd_prev; nx <= rd_next;
          state <= (rd_prev < NIL) ? S_DP : S_DN;
        end
        S_DP:  state <= S_DPW;
        S_DPW: state <= S_DN;
        S_DN: begin
          if (nx < NIL) state <= S_DNW;
          else begin
            tail[k] <= (pv < NIL) ? pv : NIL; state <= S_DFIN;
          end
        end
        S_DNW: state <= S_DFIN;
        S_DFIN: begin
          if (cnt[k] != '0) cnt[k] <= cnt[k] - 1'b1;
          // merge step of a free
          if (ret == S_FRD) begin
            if (dblk < blk) blk <= dblk;
            k <= k + 1'b1;
          end
          state <= ret;
        end
        // push dblk onto list k: block word first, then the old tail's link
        S_PT: begin
          tgt <= tail[k];
          state <= S_PB;
        end
        S_PB: begin
          tail[k] <= dblk; cnt[k] <= cnt[k] + 1'b1;
          state <= (tgt < NIL) ? S_PTR : S_PFIN;
        end
        S_PTR: state <= S_PTW;
        S_PTW: state <= S_PFIN;
        S_PFIN: state <= ret;
        // split down to the requested order
        S_SPLIT: begin
          if (k > ord) begin
            dblk <= blk + (PW'(1) << (k - 1'b1));
            k <= k - 1'b1; ret <= S_SPLIT; state <= S_PT;
          end else begin
            result <= blk[AW-1:0]; state <= S_DONE;
          end
        end
        // free: read buddy, merge or push
        S_FRD: begin
          if (32'(k) >= MAX_ORDER || buddy >= NIL) begin
            dblk <= blk; ret <= S_DONE; state <= S_PT;
          end else begin
            dblk <= buddy; state <= S_FCHK;
          end
        end
        S_FCHK: begin
          ret <= S_FRD; state <= S_DRD;
        end
        default: begin
          m_tvalid <= 1'b1;
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
      endcase
    end
  end

  logic [12:0] cnt_out;
  assign cnt_out = (32'(ord) > MAX_ORDER) ? 13'd0 : cnt[ord];
  assign m_tdata = {4'd0, cnt_out, 12'(result), status};

  // a result only appears from the done state
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> state == S_DONE)
    else $error("result valid outside done");
  // no request taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst) state == S_CLR |-> !s_tready)
    else $error("ready during clear");
  // an error status carries a zero block index
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != ST_OK) |-> result == '0)
    else $error("index on error");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for buddy_page_allocator
// A directed table of requests runs first, then order-2 frees fill the
// store, then random alloc/free traffic over a tracked set of live blocks.
// Every response word is compared with a bench model of the free lists.
// ----------------------------------------------------------------------------
module tb;
  import bpa_pkg::*;

  localparam int PAGES   = 4096;
  localparam int MAXORD  = 10;
  localparam int NIL     = PAGES;
  localparam int N_RAND  = 565;
  localparam int LIMIT   = 2000000;
  localparam logic [2:0] NO_EXP = 3'd7;   // no typed-in status

  typedef struct packed {
    logic [12:0] cnt;
    logic [11:0] blk;
    logic [2:0]  status;
  } resp_t;

  typedef struct {
    logic        req;
    logic [3:0]  ord;
    logic [11:0] idx;
    logic        has_exp;
    logic [2:0]  exp_status;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  buddy_page_allocator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // model state for the free lists
  int          tail_q[MAXORD+1];
  int          count_q[MAXORD+1];
  int          nxt[PAGES];
  int          prv[PAGES];
  int          hord[PAGES];
  bit          fhead[PAGES];

  resp_t       pending_resp[$];
  logic [2:0]  pending_dir[$];   // typed-in status, or NO_EXP
  int          errors = 0;
  int          cycles = 0;
  int          hold_left = 0;
  int          live_idx[$];
  int          live_ord[$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void unlink(input int b, input int o);
    int p, n;
    p = prv[b];
    n = nxt[b];
    if (p < NIL) nxt[p] = n;
    if (n < NIL) prv[n] = p;
    else tail_q[o] = (p < NIL) ? p : NIL;
    if (count_q[o] > 0) count_q[o]--;
    fhead[b] = 1'b0;
  endfunction

  function automatic void link_tail(input int b, input int o);
    int t;
    t = tail_q[o];
    prv[b] = t;
    nxt[b] = NIL;
    if (t < NIL) nxt[t] = b;
    tail_q[o] = b;
    count_q[o]++;
    fhead[b] = 1'b1;
    hord[b] = o;
  endfunction

  // predicts the response and updates the list model
  function automatic resp_t allocator_step(input logic rq, input int o, input int ix);
    resp_t r;
    int k, b, sz, bd;
    r = '0;
    if (o > MAXORD) begin
      r.status = ST_BAD_ORD;
      return r;
    end
    if (rq == REQ_ALLOC) begin
      b = NIL;
      for (k = o; k <= MAXORD; k++) begin
        b = tail_q[k];
        if (b < NIL) begin
          unlink(b, k);
          break;
        end
      end
      if (b >= NIL) r.status = ST_NO_MEM;
      else begin
        while (k > o) begin
          k--;
          link_tail(b + (1 << k), k);
        end
        r.blk = 12'(b);
      end
    end else begin
      sz = 1 << o;
      if (ix + sz > PAGES) r.status = ST_RANGE;
      else if ((ix & (sz - 1)) != 0) r.status = ST_MISALIGN;
      else begin
        b = ix;
        k = o;
        while (k < MAXORD) begin
          bd = b ^ (1 << k);
          if (bd >= NIL || !fhead[bd] || hord[bd] != k) break;
          unlink(bd, k);
          if (bd < b) b = bd;
          k++;
        end
        link_tail(b, k);
      end
    end
    r.cnt = 13'(count_q[o]);
    return r;
  endfunction

  // send one request word and queue its expectation; valid stays up when
  // the next word follows without a gap
  task automatic send_req(input logic rq, input int o, input int ix, input logic [2:0] dir);
    resp_t r;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = allocator_step(rq, o, ix);
    pending_resp.push_back(r);
    pending_dir.push_back(dir);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, ix[11:0], o[3:0], rq};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // response side: random stalls, check against the oldest expectation
  always @(posedge clk) begin
    resp_t got, want;
    logic [2:0] dir;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[27:0];
        if (pending_resp.size() == 0) report("unexpected word", got.status, -1);
        else begin
          want = pending_resp.pop_front();
          dir = pending_dir.pop_front();
          if (dir != NO_EXP && got.status != dir) report("status (table)", got.status, dir);
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.blk != want.blk) report("block_index", got.blk, want.blk);
          if (got.cnt != want.cnt) report("free_blocks_at_order", got.cnt, want.cnt);
        end
      end
      // mostly short stalls, now and then a long one
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        hold_left = $urandom_range(5, 40);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t tbl[$];
    row_t rw;
    int i, o, ix, pick;
    logic [2:0] dir;
    for (i = 0; i <= MAXORD; i++) begin
      tail_q[i] = NIL;
      count_q[i] = 0;
    end
    for (i = 0; i < PAGES; i++) begin
      fhead[i] = 1'b0;
      nxt[i] = 0;
      prv[i] = 0;
      hord[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table: empty store, error codes, extremes, merges
    tbl.push_back('{REQ_ALLOC, 4'd0, 12'd0, 1'b1, ST_NO_MEM});
    tbl.push_back('{REQ_ALLOC, 4'd10, 12'd0, 1'b1, ST_NO_MEM});
    tbl.push_back('{REQ_ALLOC, 4'd11, 12'd0, 1'b1, ST_BAD_ORD});
    tbl.push_back('{REQ_FREE, 4'd15, 12'hfff, 1'b1, ST_BAD_ORD});
    tbl.push_back('{REQ_FREE, 4'd0, 12'hfff, 1'b0, ST_OK});
    tbl.push_back('{REQ_FREE, 4'd1, 12'hfff, 1'b1, ST_RANGE});
    tbl.push_back('{REQ_FREE, 4'd10, 12'd3072, 1'b1, ST_OK});
    tbl.push_back('{REQ_FREE, 4'd10, 12'd3584, 1'b1, ST_RANGE});
    tbl.push_back('{REQ_FREE, 4'd3, 12'd4, 1'b1, ST_MISALIGN});
    tbl.push_back('{REQ_FREE, 4'd2, 12'd6, 1'b1, ST_MISALIGN});
    tbl.push_back('{REQ_FREE, 4'd0, 12'd0, 1'b0, ST_OK});
    tbl.push_back('{REQ_FREE, 4'd0, 12'd1, 1'b0, ST_OK});
    tbl.push_back('{REQ_FREE, 4'd1, 12'd2, 1'b0, ST_OK});
    tbl.push_back('{REQ_ALLOC, 4'd0, 12'hfff, 1'b0, ST_OK});
    tbl.push_back('{REQ_ALLOC, 4'd0, 12'd0, 1'b0, ST_OK});
    tbl.push_back('{REQ_ALLOC, 4'd3, 12'd0, 1'b0, ST_OK});
    tbl.push_back('{REQ_ALLOC, 4'd10, 12'd0, 1'b0, ST_OK});
    tbl.push_back('{REQ_ALLOC, 4'd10, 12'd0, 1'b1, ST_NO_MEM});
    foreach (tbl[j]) begin
      rw = tbl[j];
      dir = rw.has_exp ? rw.exp_status : NO_EXP;
      send_req(rw.req, rw.ord, rw.idx, dir);
    end

    // fill the store with order-2 frees of the pages below 3072, skipping page 0 and free heads
    for (i = 0; i < 1024; i++) begin
      ix = i * 4;
      if (!fhead[ix] && ix != 0 && !(ix >= 3072)) send_req(REQ_FREE, 2, ix, NO_EXP);
    end

    // random traffic: mostly well-formed allocs and frees of live blocks
    for (i = 0; i < N_RAND; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        o = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAXORD) : $urandom_range(0, 3);
        send_req(REQ_ALLOC, o, $urandom_range(0, 4095), NO_EXP);
        if (pending_resp[$].status == ST_OK) begin
          live_idx.push_back(pending_resp[$].blk);
          live_ord.push_back(o);
        end
      end else if (pick < 90 && live_idx.size() > 0) begin
        ix = $urandom_range(0, live_idx.size() - 1);
        send_req(REQ_FREE, live_ord[ix], live_idx[ix], NO_EXP);
        live_idx.delete(ix);
        live_ord.delete(ix);
      end else if (pick < 95) begin
        // broken free: bad order, out of range or misaligned only
        o = $urandom_range(1, 15);
        ix = $urandom_range(0, 4095);
        if (o <= MAXORD && ix + (1 << o) <= PAGES) ix = ix | 1;
        send_req(REQ_FREE, o, ix, NO_EXP);
      end else begin
        send_req(REQ_ALLOC, $urandom_range(11, 15), $urandom_range(0, 4095), NO_EXP);
      end
    end
    s_tvalid <= 1'b0;

    // drain
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: buddy_page_allocator.f
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/buddy_page_allocator.sv
tb/tb.sv
